@@ hw/rtl/qas_pkg.sv @@
`default_nettype none

package qas_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // Parser modes
  typedef enum logic [3:0] {
    M_SKIP      = 4'd0,
    M_PLAIN     = 4'd1,
    M_DQ        = 4'd2,
    M_DQ_ESC    = 4'd3,
    M_DQ_X      = 4'd4,
    M_DQ_XH_LOW = 4'd5,
    M_DQ_XH_UP  = 4'd6,
    M_SQ        = 4'd7,
    M_SQ_ESC    = 4'd8,
    M_AFTER     = 4'd9,
    M_DROP      = 4'd10
  } mode_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } res_t;

  localparam int MaxResults = 3;

  // All results caused by one input item; count is 1 to 3
  typedef struct packed {
    logic [1:0]                count;
    res_t [MaxResults-1:0]     res;
  } bundle_t;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6e;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_X   = 8'h78;

  localparam logic [7:0] HexTen = 8'd10;

endpackage

`default_nettype wire

@@ hw/rtl/qas_front.sv @@
`default_nettype none

module qas_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       char_in,
  input  wire logic             end_of_line,
  output qas_pkg::bundle_t      bundle,
  output logic                  has_results
);

  qas_pkg::mode_t mode, mode_next;
  logic [3:0]     hex, hex_next;

  logic       term;
  logic       is_hex;
  logic       hex_up;
  logic [3:0] hv;
  logic       is_ws;
  logic       is_sep;
  logic [7:0] esc_byte;
  logic [7:0] held_char;

  // Candidate results in emission order: two prefix bytes, two tail results
  logic             p0_v, p1_v, t0_v, t1_v;
  logic [7:0]       p0_val, p1_val, t0_val;
  qas_pkg::kind_t   t0_kind, t1_kind;
  logic             run_dq, run_sq, run_plain;
  logic [1:0]       cnt;

  // Classify the byte
  always_comb begin
    term   = end_of_line || (char_in == qas_pkg::CH_NUL);
    hex_up = (char_in >= qas_pkg::CH_UP_A) && (char_in <= qas_pkg::CH_UP_F);
    is_hex = 1'b0;
    hv     = 4'd0;
    if ((char_in >= qas_pkg::CH_ZERO) && (char_in <= qas_pkg::CH_NINE)) begin
      is_hex = 1'b1;
      hv     = 4'(char_in - qas_pkg::CH_ZERO);
    end else if ((char_in >= qas_pkg::CH_LO_A) && (char_in <= qas_pkg::CH_LO_F)) begin
      is_hex = 1'b1;
      hv     = 4'(char_in - qas_pkg::CH_LO_A + qas_pkg::HexTen);
    end else if (hex_up) begin
      is_hex = 1'b1;
      hv     = 4'(char_in - qas_pkg::CH_UP_A + qas_pkg::HexTen);
    end
    is_sep = (char_in == qas_pkg::CH_SPACE) || (char_in == qas_pkg::CH_TAB) ||
             (char_in == qas_pkg::CH_LF) || (char_in == qas_pkg::CH_CR);
    is_ws  = is_sep || (char_in == qas_pkg::CH_VT) || (char_in == qas_pkg::CH_FF);
    case (char_in)
      qas_pkg::CH_LO_N: esc_byte = qas_pkg::CH_LF;
      qas_pkg::CH_LO_R: esc_byte = qas_pkg::CH_CR;
      qas_pkg::CH_LO_T: esc_byte = qas_pkg::CH_TAB;
      qas_pkg::CH_LO_B: esc_byte = qas_pkg::CH_BS;
      qas_pkg::CH_LO_A: esc_byte = qas_pkg::CH_BEL;
      default:          esc_byte = char_in;
    endcase
    // Rebuild the held hex digit as it was typed
    if (hex < 4'd10) begin
      held_char = qas_pkg::CH_ZERO + {4'd0, hex};
    end else if (mode == qas_pkg::M_DQ_XH_UP) begin
      held_char = qas_pkg::CH_UP_A + {4'd0, hex} - qas_pkg::HexTen;
    end else begin
      held_char = qas_pkg::CH_LO_A + {4'd0, hex} - qas_pkg::HexTen;
    end
  end

  // Next mode and candidate results
  always_comb begin
    p0_v      = 1'b0;
    p0_val    = 8'd0;
    p1_v      = 1'b0;
    p1_val    = 8'd0;
    t0_v      = 1'b0;
    t0_kind   = qas_pkg::KIND_BYTE;
    t0_val    = 8'd0;
    t1_v      = 1'b0;
    t1_kind   = qas_pkg::KIND_OK;
    mode_next = mode;
    hex_next  = hex;
    run_dq    = 1'b0;
    run_sq    = 1'b0;
    run_plain = 1'b0;
    case (mode)
      qas_pkg::M_PLAIN: begin
        run_plain = 1'b1;
      end
      qas_pkg::M_DQ: begin
        run_dq = 1'b1;
      end
      qas_pkg::M_DQ_ESC: begin
        if (term) begin
          p0_v      = 1'b1;
          p0_val    = qas_pkg::CH_BSLASH;
          t0_v      = 1'b1;
          t0_kind   = qas_pkg::KIND_ERR;
          mode_next = qas_pkg::M_SKIP;
        end else if (char_in == qas_pkg::CH_LO_X) begin
          mode_next = qas_pkg::M_DQ_X;
        end else begin
          p0_v      = 1'b1;
          p0_val    = esc_byte;
          mode_next = qas_pkg::M_DQ;
        end
      end
      qas_pkg::M_DQ_X: begin
        if (!term && is_hex) begin
          hex_next  = hv;
          mode_next = hex_up ? qas_pkg::M_DQ_XH_UP : qas_pkg::M_DQ_XH_LOW;
        end else begin
          p0_v   = 1'b1;
          p0_val = qas_pkg::CH_LO_X;
          run_dq = 1'b1;
        end
      end
      qas_pkg::M_DQ_XH_LOW, qas_pkg::M_DQ_XH_UP: begin
        if (!term && is_hex) begin
          p0_v      = 1'b1;
          p0_val    = {hex, hv};
          mode_next = qas_pkg::M_DQ;
        end else begin
          p0_v   = 1'b1;
          p0_val = qas_pkg::CH_LO_X;
          p1_v   = 1'b1;
          p1_val = held_char;
          run_dq = 1'b1;
        end
      end
      qas_pkg::M_SQ: begin
        run_sq = 1'b1;
      end
      qas_pkg::M_SQ_ESC: begin
        if (!term && (char_in == qas_pkg::CH_SQUOTE)) begin
          p0_v      = 1'b1;
          p0_val    = qas_pkg::CH_SQUOTE;
          mode_next = qas_pkg::M_SQ;
        end else begin
          p0_v   = 1'b1;
          p0_val = qas_pkg::CH_BSLASH;
          run_sq = 1'b1;
        end
      end
      qas_pkg::M_AFTER: begin
        if (term) begin
          t0_v      = 1'b1;
          t0_kind   = qas_pkg::KIND_END;
          t1_v      = 1'b1;
          t1_kind   = qas_pkg::KIND_OK;
          mode_next = qas_pkg::M_SKIP;
        end else if (is_ws) begin
          t0_v      = 1'b1;
          t0_kind   = qas_pkg::KIND_END;
          mode_next = qas_pkg::M_SKIP;
        end else begin
          t0_v      = 1'b1;
          t0_kind   = qas_pkg::KIND_ERR;
          mode_next = qas_pkg::M_DROP;
        end
      end
      qas_pkg::M_DROP: begin
        if (term) begin
          mode_next = qas_pkg::M_SKIP;
        end
      end
      default: begin
        // Between tokens; unknown modes land here too
        if (term) begin
          t0_v      = 1'b1;
          t0_kind   = qas_pkg::KIND_OK;
          mode_next = qas_pkg::M_SKIP;
        end else if (is_ws) begin
          mode_next = qas_pkg::M_SKIP;
        end else begin
          run_plain = 1'b1;
        end
      end
    endcase

    // Byte inside double quotes
    if (run_dq) begin
      if (term) begin
        t0_v      = 1'b1;
        t0_kind   = qas_pkg::KIND_ERR;
        mode_next = qas_pkg::M_SKIP;
      end else if (char_in == qas_pkg::CH_BSLASH) begin
        mode_next = qas_pkg::M_DQ_ESC;
      end else if (char_in == qas_pkg::CH_DQUOTE) begin
        mode_next = qas_pkg::M_AFTER;
      end else begin
        t0_v      = 1'b1;
        t0_val    = char_in;
        mode_next = qas_pkg::M_DQ;
      end
    end

    // Byte inside single quotes
    if (run_sq) begin
      if (term) begin
        t0_v      = 1'b1;
        t0_kind   = qas_pkg::KIND_ERR;
        mode_next = qas_pkg::M_SKIP;
      end else if (char_in == qas_pkg::CH_BSLASH) begin
        mode_next = qas_pkg::M_SQ_ESC;
      end else if (char_in == qas_pkg::CH_SQUOTE) begin
        mode_next = qas_pkg::M_AFTER;
      end else begin
        t0_v      = 1'b1;
        t0_val    = char_in;
        mode_next = qas_pkg::M_SQ;
      end
    end

    // Byte of an unquoted token
    if (run_plain) begin
      if (term) begin
        t0_v      = 1'b1;
        t0_kind   = qas_pkg::KIND_END;
        t1_v      = 1'b1;
        t1_kind   = qas_pkg::KIND_OK;
        mode_next = qas_pkg::M_SKIP;
      end else if (is_sep) begin
        t0_v      = 1'b1;
        t0_kind   = qas_pkg::KIND_END;
        mode_next = qas_pkg::M_SKIP;
      end else if (char_in == qas_pkg::CH_DQUOTE) begin
        mode_next = qas_pkg::M_DQ;
      end else if (char_in == qas_pkg::CH_SQUOTE) begin
        mode_next = qas_pkg::M_SQ;
      end else begin
        t0_v      = 1'b1;
        t0_val    = char_in;
        mode_next = qas_pkg::M_PLAIN;
      end
    end
  end

  // Pack the candidates into consecutive slots
  always_comb begin
    bundle = '0;
    cnt    = 2'd0;
    if (p0_v) begin
      bundle.res[cnt] = '{kind: qas_pkg::KIND_BYTE, value: p0_val};
      cnt             = cnt + 2'd1;
    end
    if (p1_v) begin
      bundle.res[cnt] = '{kind: qas_pkg::KIND_BYTE, value: p1_val};
      cnt             = cnt + 2'd1;
    end
    if (t0_v && (cnt != 2'd3)) begin
      bundle.res[cnt] = '{kind: t0_kind,
                          value: (t0_kind == qas_pkg::KIND_BYTE) ? t0_val : 8'd0};
      cnt             = cnt + 2'd1;
    end
    if (t1_v && (cnt != 2'd3)) begin
      bundle.res[cnt] = '{kind: t1_kind, value: 8'd0};
      cnt             = cnt + 2'd1;
    end
    bundle.count = cnt;
    has_results  = (cnt != 2'd0);
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= qas_pkg::M_SKIP;
      hex  <= 4'd0;
    end else if (take) begin
      mode <= mode_next;
      hex  <= hex_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/qas_queue.sv @@
`default_nettype none

module qas_queue #(
  parameter int Depth = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire qas_pkg::bundle_t push_data,
  input  wire logic             pop,
  output qas_pkg::bundle_t      head,
  output logic                  full,
  output logic                  empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  qas_pkg::bundle_t slots [Depth];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign head  = slots[rd_ptr[AW-1:0]];

  // Store a bundle
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[AW-1:0]] <= push_data;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + (AW+1)'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/qas_back.sv @@
`default_nettype none

module qas_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qas_pkg::bundle_t head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            kind,
  output logic [7:0]            value,
  output logic                  last
);

  logic [1:0]      idx;
  qas_pkg::res_t   cur;

  // Present the current result of the head bundle
  always_comb begin
    cur       = head.res[idx];
    out_valid = !empty;
    kind      = cur.kind;
    value     = cur.value;
    last      = (idx == (head.count - 2'd1));
    pop       = out_valid && out_ready && last;
  end

  // Step through the bundle, drop it after its last result
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/quoted_argument_splitter.sv @@
// Quoted argument splitter.
// Input channel (in_valid/in_ready): one byte of a line per transfer in
// char_in, or a line terminator (end_of_line, or char_in of zero).
// Output channel (out_valid/out_ready): result items kind/value/last; a
// byte gives zero to three results, last marks the final one of a byte.
// The parser takes one byte per cycle while in_ready is high and writes
// all results of that byte as one bundle into a queue of QueueDepth
// bundles; the output side reads one result per cycle from the queue head
// while out_ready is high. The first result of a byte is presented once
// its bundle, registered in the queue, reaches the head; a byte with
// several results holds the head until all of them are taken.
// in_ready falls only while the queue is full, so a stalled receiver
// blocks the input once QueueDepth bundles wait; nothing is lost.
// Reset clears the queue and returns the parser to between tokens.
// QueueDepth must be a power of two, at least 2.
`default_nettype none

module quoted_argument_splitter #(
  parameter int QueueDepth = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_in,
  input  wire logic       end_of_line,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      value,
  output logic            last
);

  qas_pkg::bundle_t bundle;
  qas_pkg::bundle_t head;
  logic             has_results;
  logic             take;
  logic             full;
  logic             empty;
  logic             pop;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  // Parse one byte per transfer
  qas_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .char_in     (char_in),
    .end_of_line (end_of_line),
    .bundle      (bundle),
    .has_results (has_results)
  );

  // Buffer result bundles between parser and output
  qas_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take && has_results),
    .push_data (bundle),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  // Deliver results one per transfer
  qas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .value     (value),
    .last      (last)
  );

endmodule

`default_nettype wire
